@@ rtl/core/fpp_pkg.sv @@
`timescale 1ns / 1ps

package fpp_pkg;

  localparam int DIGEST_BYTES = 32;
  localparam int SIZE_BYTES   = 4;

  localparam logic [7:0] MAX_TYPE_RESET = 8'd8;

  typedef enum logic [2:0] {
    ROLE_TYPE    = 3'd0,
    ROLE_NLEN    = 3'd1,
    ROLE_NAME    = 3'd2,
    ROLE_SIZE    = 3'd3,
    ROLE_DIGEST  = 3'd4,
    ROLE_CONTENT = 3'd5,
    ROLE_REJECT  = 3'd6
  } byte_role_t;

  typedef struct packed {
    byte_role_t  role;
    logic [7:0]  value;
    logic [7:0]  offset;
    logic [7:0]  rec_type;
    logic [7:0]  name_len;
    logic [31:0] file_size;
    logic [31:0] remaining;
    logic        hdr_done;
    logic        last;
    logic        err;
  } parse_res_t;

endpackage

@@ rtl/core/fpp_parser.sv @@
`timescale 1ns / 1ps

module fpp_parser
  import fpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] data_byte,
  input  logic [7:0] max_type,
  output parse_res_t res
);

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_NLEN,
    PH_NAME,
    PH_SIZE,
    PH_DIGEST,
    PH_CONTENT
  } phase_t;

  localparam logic [7:0] DIGEST_LEN = 8'(DIGEST_BYTES);
  localparam logic [7:0] SIZE_LEN   = 8'(SIZE_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  nlen_r, nlen_nxt;
  logic [7:0]  fcnt_r, fcnt_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] rcvd_r, rcvd_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  fcnt_inc;
  logic [31:0] rcvd_inc;
  logic [31:0] size_merge;

  assign fcnt_inc   = fcnt_r + 8'd1;
  assign rcvd_inc   = rcvd_r + 32'd1;
  assign size_merge = size_r | ({24'd0, data_byte} << {fcnt_r[1:0], 3'b000});

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    nlen_nxt  = nlen_r;
    fcnt_nxt  = fcnt_r;
    size_nxt  = size_r;
    rcvd_nxt  = rcvd_r;
    err_nxt   = err_r;

    res.role      = ROLE_REJECT;
    res.value     = data_byte;
    res.offset    = 8'd0;
    res.remaining = 32'd0;
    res.hdr_done  = 1'b0;
    res.last      = 1'b0;

    if (!err_r) begin
      case (phase_r)
        PH_NLEN: begin
          res.role = ROLE_NLEN;
          nlen_nxt = data_byte;
          if (data_byte == 8'd0) begin
            err_nxt = 1'b1;
          end else begin
            fcnt_nxt  = 8'd0;
            phase_nxt = PH_NAME;
          end
        end
        PH_NAME: begin
          res.role   = ROLE_NAME;
          res.offset = fcnt_r;
          fcnt_nxt   = fcnt_inc;
          if (fcnt_inc >= nlen_r) begin
            fcnt_nxt  = 8'd0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_SIZE: begin
          res.role   = ROLE_SIZE;
          res.offset = fcnt_r;
          size_nxt   = size_merge;
          fcnt_nxt   = fcnt_inc;
          if (fcnt_inc >= SIZE_LEN) begin
            fcnt_nxt  = 8'd0;
            phase_nxt = PH_DIGEST;
          end
        end
        PH_DIGEST: begin
          res.role      = ROLE_DIGEST;
          res.offset    = fcnt_r;
          res.remaining = size_r - rcvd_r;
          fcnt_nxt      = fcnt_inc;
          if (fcnt_inc >= DIGEST_LEN) begin
            fcnt_nxt      = 8'd0;
            res.hdr_done  = 1'b1;
            rcvd_nxt      = 32'd0;
            res.remaining = size_r;
            if (size_r == 32'd0) begin
              res.last  = 1'b1;
              phase_nxt = PH_TYPE;
            end else begin
              phase_nxt = PH_CONTENT;
            end
          end
        end
        PH_CONTENT: begin
          res.role      = ROLE_CONTENT;
          rcvd_nxt      = rcvd_inc;
          res.remaining = size_r - rcvd_inc;
          if (rcvd_inc >= size_r) begin
            res.remaining = 32'd0;
            res.last      = 1'b1;
            phase_nxt     = PH_TYPE;
          end
        end
        default: begin
          res.role = ROLE_TYPE;
          type_nxt = data_byte;
          size_nxt = 32'd0;
          rcvd_nxt = 32'd0;
          fcnt_nxt = 8'd0;
          if (data_byte == 8'd0 || data_byte > max_type) begin
            err_nxt = 1'b1;
          end else begin
            phase_nxt = PH_NLEN;
          end
        end
      endcase
    end

    res.rec_type  = type_nxt;
    res.name_len  = nlen_nxt;
    res.file_size = size_nxt;
    res.err       = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r  <= 8'd0;
      nlen_r  <= 8'd0;
      fcnt_r  <= 8'd0;
      size_r  <= 32'd0;
      rcvd_r  <= 32'd0;
      err_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      nlen_r  <= nlen_nxt;
      fcnt_r  <= fcnt_nxt;
      size_r  <= size_nxt;
      rcvd_r  <= rcvd_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ rtl/core/file_pack_header_and_body_parser.sv @@
`timescale 1ns / 1ps
// Each accepted item is captured in the output register and appears on the output in the next cycle.
// Throughput is one item per cycle while out_tready is high, and an item is taken while the output register drains.
// The parse state lives in the parser, and the output register is the only stage.
// Reset is synchronous and active low, and returns the parser to expect a type byte.
// Reset also clears the sticky error and sets the type limit back to eight.

module file_pack_header_and_body_parser
  import fpp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // byte_value, field_offset, record_type, name_length, file_size, bytes_remaining,
  // header_done, format_error, zero fill
  output logic [103:0] out_tdata,
  output logic [2:0]   out_tuser,   // byte_role
  output logic         out_tlast    // file_last
);

  logic       max_type_r;
  logic [7:0] max_type_val_r;
  logic       accept;
  logic       out_tvalid_r, out_tvalid_nxt;
  parse_res_t res;
  parse_res_t out_res_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_type_val_r <= MAX_TYPE_RESET;
      max_type_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      max_type_val_r <= cfg_wr_data;
      max_type_r     <= 1'b1;
    end
  end

  fpp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (accept),
    .data_byte (in_tdata),
    .max_type  (max_type_val_r),
    .res       (res)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (accept) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_res_r.role;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {6'd0, out_res_r.err, out_res_r.hdr_done, out_res_r.remaining,
                       out_res_r.file_size, out_res_r.name_len, out_res_r.rec_type,
                       out_res_r.offset, out_res_r.value};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid_r |-> in_tready)
    else $error("input stalled while the output register is empty");

  a_reject_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_res_r.role == ROLE_REJECT |-> out_res_r.err)
    else $error("rejected item without error flag");

  a_hdr_on_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_res_r.hdr_done |-> out_res_r.role == ROLE_DIGEST)
    else $error("header end on an item that is not a digest byte");

  a_last_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_res_r.last |->
      out_res_r.role == ROLE_DIGEST || out_res_r.role == ROLE_CONTENT)
    else $error("record end on an item that is neither digest nor content");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    accept && $past(accept) && $past(res.err) |-> res.err)
    else $error("format error cleared without reset");

  a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> max_type_r && max_type_val_r == $past(cfg_wr_data))
    else $error("type limit write lost");

endmodule
